// ----- rtl/setq_pkg.sv -----
package setq_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_BITS  = 8;
    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int QDEPTH   = 2;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_DUP      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EX_IDLE,
        EX_REMOVE,
        EX_INSERT,
        EX_TICK
    } ex_state_t;

    // one classified request passed from front to back
    typedef struct packed {
        cmd_t               cmd;
        logic [ID_BITS-1:0] id;
        logic [31:0]        expire;
        logic [31:0]        now;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        fired;
        logic [7:0]  fired_id;
        logic        last;
    } rsp_t;

endpackage

// ----- rtl/setq_front.sv -----
// Accept requests, trim the id and hold them in a short queue for the back.
module setq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic [7:0]           timer_id,
    input  logic [31:0]          new_expire,
    input  logic [31:0]          now_time,
    output logic                 q_valid,
    input  logic                 q_pop,
    output setq_pkg::req_t       q_req
);
    localparam int PB = $clog2(setq_pkg::QDEPTH);

    setq_pkg::req_t      mem_reg [setq_pkg::QDEPTH];
    logic [PB-1:0]       wp_reg, rp_reg;
    logic [PB:0]         cnt_reg;
    logic                push;
    setq_pkg::req_t      req_in;

    assign in_stall = (cnt_reg == (PB+1)'(setq_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = mem_reg[rp_reg];

    // classify the incoming request
    always_comb
    begin
        req_in.cmd    = setq_pkg::cmd_t'(command);
        req_in.id     = timer_id[setq_pkg::ID_BITS-1:0];
        req_in.expire = new_expire;
        req_in.now    = now_time;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= req_in;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PB+1)'(push) - (PB+1)'(q_pop);
        end
    end
endmodule

// ----- rtl/setq_back.sv -----
// Sorted cell array: search, remove, insert and drain expired heads.
module setq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  setq_pkg::req_t       q_req,
    output logic                 out_valid,
    input  logic                 out_stall,
    output setq_pkg::rsp_t       out_rsp
);
    localparam int D  = setq_pkg::DEPTH;
    localparam int IB = setq_pkg::IDX_BITS;
    localparam int CB = setq_pkg::CNT_BITS;
    localparam int IDB = setq_pkg::ID_BITS;

    logic [31:0]          exp_reg [D];
    logic [IDB-1:0]       hnd_reg [D];
    logic [CB-1:0]        count_reg;
    setq_pkg::ex_state_t  state_reg, state_next;
    setq_pkg::req_t       cur_reg;
    logic                 any_fired_reg;
    logic                 out_valid_reg;
    setq_pkg::rsp_t       out_reg;

    logic [D-1:0]         valid_v, hit_v, le_v;
    logic                 found;
    logic [IB-1:0]        hit_pos;
    logic                 out_free;
    logic                 head_exp;
    logic                 do_remove, do_insert, do_tick_pop;
    logic                 emit;
    setq_pkg::rsp_t       emit_rsp;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    // per-cell compares
    always_comb
    begin
        found   = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < D; i++)
        begin
            valid_v[i] = (CB'(i) < count_reg);
            hit_v[i]   = valid_v[i] && (hnd_reg[i] == cur_reg.id);
            le_v[i]    = valid_v[i] && (exp_reg[i] <= cur_reg.expire);
        end
        for (int i = D - 1; i >= 0; i--)
        begin
            if (hit_v[i])
            begin
                found   = 1'b1;
                hit_pos = IB'(i);
            end
        end
    end

    assign head_exp = (count_reg != '0) && (exp_reg[0] <= cur_reg.now);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            setq_pkg::EX_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_req.cmd)
                        setq_pkg::CMD_ADD:    state_next = setq_pkg::EX_INSERT;
                        setq_pkg::CMD_TICK:   state_next = setq_pkg::EX_TICK;
                        default:              state_next = setq_pkg::EX_REMOVE;
                    endcase
                end
            end
            setq_pkg::EX_REMOVE:
            begin
                if (out_free)
                begin
                    if (found && cur_reg.cmd == setq_pkg::CMD_ADJUST)
                    begin
                        state_next = setq_pkg::EX_INSERT;
                    end
                    else
                    begin
                        state_next = setq_pkg::EX_IDLE;
                    end
                end
            end
            setq_pkg::EX_INSERT:
            begin
                if (out_free)
                begin
                    state_next = setq_pkg::EX_IDLE;
                end
            end
            setq_pkg::EX_TICK:
            begin
                if (out_free && !head_exp)
                begin
                    state_next = setq_pkg::EX_IDLE;
                end
            end
            default: state_next = setq_pkg::EX_IDLE;
        endcase
    end

    // outputs of each state
    always_comb
    begin
        q_pop       = 1'b0;
        do_remove   = 1'b0;
        do_insert   = 1'b0;
        do_tick_pop = 1'b0;
        emit        = 1'b0;
        emit_rsp    = '{setq_pkg::ST_OK, 1'b0, 8'd0, 1'b1};
        case (state_reg)
            setq_pkg::EX_IDLE:
            begin
                q_pop = q_valid;
            end
            setq_pkg::EX_REMOVE:
            begin
                if (out_free)
                begin
                    do_remove = found;
                    if (!found)
                    begin
                        emit            = 1'b1;
                        emit_rsp.status = setq_pkg::ST_NOTFOUND;
                    end
                    else if (cur_reg.cmd == setq_pkg::CMD_DELETE)
                    begin
                        emit = 1'b1;
                    end
                end
            end
            setq_pkg::EX_INSERT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (cur_reg.cmd == setq_pkg::CMD_ADD && found)
                    begin
                        emit_rsp.status = setq_pkg::ST_DUP;
                    end
                    else if (count_reg == CB'(D))
                    begin
                        emit_rsp.status = setq_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_insert = 1'b1;
                    end
                end
            end
            setq_pkg::EX_TICK:
            begin
                if (out_free)
                begin
                    if (head_exp)
                    begin
                        // last is set only if the next head does not expire
                        do_tick_pop       = 1'b1;
                        emit              = 1'b1;
                        emit_rsp.fired    = 1'b1;
                        emit_rsp.fired_id = 8'(hnd_reg[0]);
                        emit_rsp.last     = !((count_reg > CB'(1)) &&
                                              (exp_reg[1] <= cur_reg.now));
                    end
                    else if (!any_fired_reg)
                    begin
                        emit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // shift cells for remove, tick pop and insert
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_req;
        end
        for (int i = 0; i < D; i++)
        begin
            if (do_remove || do_tick_pop)
            begin
                if (i < D - 1 && (do_tick_pop || IB'(i) >= hit_pos))
                begin
                    exp_reg[i] <= exp_reg[i+1];
                    hnd_reg[i] <= hnd_reg[i+1];
                end
            end
            else if (do_insert)
            begin
                if (!le_v[i] && (i == 0 || le_v[i-1]))
                begin
                    exp_reg[i] <= cur_reg.expire;
                    hnd_reg[i] <= cur_reg.id;
                end
                else if (i > 0 && !le_v[i] && !le_v[i-1])
                begin
                    exp_reg[i] <= exp_reg[i-1];
                    hnd_reg[i] <= hnd_reg[i-1];
                end
            end
        end
        if (emit)
        begin
            out_reg <= emit_rsp;
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= setq_pkg::EX_IDLE;
            count_reg     <= '0;
            any_fired_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_remove || do_tick_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (do_insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (q_pop)
            begin
                any_fired_reg <= 1'b0;
            end
            else if (do_tick_pop)
            begin
                any_fired_reg <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/sorted_expiry_timer_queue_unit.sv -----
// channel | direction | fields
// in      | request   | command, timer_id, new_expire, now_time
// out     | result    | status, fired, fired_id, last
// The back pops a request in its idle state, then runs its steps: an add runs
// the insert step, a delete the remove step and an adjust both (only the
// remove step for an unknown id), set by the back's command sequencer (one
// search/remove step, one insert step). A tick drains one head a cycle while
// the result is not stalled. Reset empties the queue at once; no clearing pass.
// A stalled result holds the back; the front queue still takes two requests.
module sorted_expiry_timer_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  timer_id,
    input  logic [31:0] new_expire,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        fired,
    output logic [7:0]  fired_id,
    output logic        last
);
    logic            q_valid, q_pop;
    setq_pkg::req_t  q_req;
    setq_pkg::rsp_t  rsp;

    setq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .timer_id(timer_id), .new_expire(new_expire),
        .now_time(now_time), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    setq_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_req(q_req), .out_valid(out_valid), .out_stall(out_stall),
        .out_rsp(rsp)
    );

    assign status   = rsp.status;
    assign fired    = rsp.fired;
    assign fired_id = rsp.fired_id;
    assign last     = rsp.last;
endmodule

// ----- rtl/setq_checker.sv -----
module setq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        fired,
    input logic [7:0]  fired_id,
    input logic        last
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
        else $error("stalled result changed");

    // fired results always report ok
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> status == setq_pkg::ST_OK)
        else $error("fired result with error status");

    // non-fired results are single and carry id zero
    a_plain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> last && fired_id == 8'd0)
        else $error("plain result malformed");
endmodule

bind sorted_expiry_timer_queue_unit setq_checker u_setq_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .fired(fired), .fired_id(fired_id), .last(last)
);
